// ===== src/thick_line_rasterizer_top_defines.svh =====
// assertion macros used by the rasterizer controller
`ifndef THICK_LINE_RASTERIZER_TOP_DEFINES_SVH
`define THICK_LINE_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication under asynchronous reset
`define TLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous reset
`define TLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tlr_pkg.sv =====
// types, codes and point tables of the thick line rasterizer
package tlr_pkg;

	localparam int CoordBits = 16;
	localparam int RingBits = 9;
	localparam int ErrBits = 19;
	localparam int DblBits = 18;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [CoordBits:0] pix_t;
	typedef logic signed [RingBits-1:0] ring_t;

	typedef enum logic [1:0] {ST_IDLE, ST_PRE, ST_EMIT, ST_OUT} ctrl_state_t;

	typedef enum logic [3:0] {
		OCT_NONE, OCT_1, OCT_2, OCT_3, OCT_4, OCT_5, OCT_6, OCT_7, OCT_8
	} oct_t;

	typedef enum logic [3:0] {
		MODE_FULL, MODE_D1, MODE_D2, MODE_D3, MODE_D4, MODE_D5, MODE_D6, MODE_D7, MODE_D8
	} brush_mode_t;

	typedef enum logic [2:0] {
		PT_XY, PT_YX, PT_NXY, PT_NYX, PT_NYNX, PT_NXNY, PT_XNY, PT_YNX
	} pt_code_t;

	// register indexes on the configuration port
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_COLOR = 1'b1;

	typedef struct packed {
		logic load;
		logic take;
		logic step;
	} tlr_cmd_t;

	typedef struct packed {
		logic pend_valid;
		logic busy;
		logic found;
	} tlr_status_t;

	localparam pt_code_t FULL_X0[4] = '{PT_XY, PT_YX, PT_NYX, PT_XNY};
	localparam pt_code_t FULL_Y0[4] = '{PT_XY, PT_YX, PT_NXY, PT_YNX};
	localparam pt_code_t FULL_GEN[8] = '{PT_XNY, PT_YNX, PT_YX, PT_XY,
		PT_NXY, PT_NYX, PT_NYNX, PT_NXNY};
	localparam pt_code_t FULL_DIAG[4] = '{PT_YX, PT_NXY, PT_XNY, PT_NXNY};

	// points per ring step
	function automatic logic [3:0] point_count(brush_mode_t mode, ring_t x, ring_t y);
		logic [3:0] n;
		n = 4'd4;
		if (mode == MODE_FULL && x != 0 && y != 0 && x != y)
			n = 4'd8;
		return n;
	endfunction

	// symmetric point selected for one index
	function automatic pt_code_t point_code(brush_mode_t mode, ring_t x, ring_t y,
			logic [2:0] idx);
		pt_code_t c;
		c = PT_XY;
		case (mode)
			MODE_FULL: begin
				if (x == 0) c = FULL_X0[idx[1:0]];
				else if (y == 0) c = FULL_Y0[idx[1:0]];
				else if (x != y) c = FULL_GEN[idx];
				else c = FULL_DIAG[idx[1:0]];
			end
			MODE_D1: begin
				case (idx[1:0])
					2'd0: c = PT_XY; 2'd1: c = PT_YX; 2'd2: c = PT_NXY; default: c = PT_YNX;
				endcase
			end
			MODE_D2: begin
				case (idx[1:0])
					2'd0: c = PT_YX; 2'd1: c = PT_XY; 2'd2: c = PT_NXY; default: c = PT_NYX;
				endcase
			end
			MODE_D3: begin
				case (idx[1:0])
					2'd0: c = PT_XY; 2'd1: c = PT_NXY; 2'd2: c = PT_NYX; default: c = PT_NYNX;
				endcase
			end
			MODE_D4: begin
				case (idx[1:0])
					2'd0: c = PT_NXY; 2'd1: c = PT_NYX; 2'd2: c = PT_NYNX; default: c = PT_NXNY;
				endcase
			end
			MODE_D5: begin
				case (idx[1:0])
					2'd0: c = PT_XNY; 2'd1: c = PT_NYX; 2'd2: c = PT_NYNX; default: c = PT_NXNY;
				endcase
			end
			MODE_D6: begin
				case (idx[1:0])
					2'd0: c = PT_XNY; 2'd1: c = PT_YNX; 2'd2: c = PT_NYNX; default: c = PT_NXNY;
				endcase
			end
			MODE_D7: begin
				case (idx[1:0])
					2'd0: c = PT_XNY; 2'd1: c = PT_YNX; 2'd2: c = PT_YX; default: c = PT_NXNY;
				endcase
			end
			MODE_D8: begin
				case (idx[1:0])
					2'd0: c = PT_XNY; 2'd1: c = PT_YNX; 2'd2: c = PT_YX; default: c = PT_XY;
				endcase
			end
			default: c = PT_XY;
		endcase
		return c;
	endfunction

endpackage

// ===== src/tlr_ifs.sv =====
// handshake channels of the rasterizer
interface tlr_line_if import tlr_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tlr_pixel_if import tlr_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel_x;
	pix_t pixel_y;
	logic [31:0] color;
	logic last;
	modport source (output valid, pixel_x, pixel_y, color, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, color, last, output ready);
endinterface

interface tlr_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/thick_line_rasterizer_top.sv =====
// A load starts the prefetch search for the first pixel and outputs no pixel.
// A tick with a pixel pending presents it once the search for the next pixel ends.
// A new load or tick is taken only when idle, after the last pixel has transferred; each ring
// step and walk step is a step of the shared search unit in the datapath.
// Reset: asynchronous, active low; idle, no pixel pending, configuration registers zero.
module thick_line_rasterizer_top import tlr_pkg::*; (
	input logic clk,
	input logic arst_n,
	tlr_line_if.sink line_in,
	tlr_pixel_if.source pixel_out,
	tlr_cfg_if.sink cfg
);

	logic [5:0] radius_q;
	logic [31:0] color_q;
	tlr_cmd_t cmd;
	tlr_status_t status;

	// configuration registers, every write transfer taken at once
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			color_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RADIUS: radius_q <= cfg.data[5:0];
				REG_COLOR: color_q <= cfg.data;
				default: color_q <= color_q;
			endcase
		end
	end

	tlr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(line_in.valid),
		.in_cmd(line_in.cmd),
		.in_ready(line_in.ready),
		.out_valid(pixel_out.valid),
		.out_ready(pixel_out.ready),
		.status(status),
		.cmd(cmd)
	);

	tlr_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.start_x(line_in.start_x),
		.start_y(line_in.start_y),
		.end_x(line_in.end_x),
		.end_y(line_in.end_y),
		.radius(radius_q),
		.pixel_x(pixel_out.pixel_x),
		.pixel_y(pixel_out.pixel_y),
		.last(pixel_out.last)
	);

	assign pixel_out.color = color_q;

endmodule

// ===== src/tlr_ctrl.sv =====
// controller: sequences load, prefetch search and pixel transfer
`include "thick_line_rasterizer_top_defines.svh"

module tlr_ctrl import tlr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_cmd,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input tlr_status_t status,
	output tlr_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !in_cmd) state_d = ST_PRE;
				else if (in_fire && status.pend_valid) state_d = ST_EMIT;
			end
			ST_PRE: begin
				if (!status.busy || status.found) state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (!status.busy || status.found) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire && !in_cmd;
				cmd.take = in_fire && in_cmd && status.pend_valid;
			end
			ST_PRE, ST_EMIT: begin
				cmd.step = 1'b1;
			end
			ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`TLR_ASSERT_NEXT(a_load_prefetch, clk, arst_n, in_fire && !in_cmd, state_q == ST_PRE,
		"load did not start prefetch")
	`TLR_ASSERT_NEXT(a_tick_emit, clk, arst_n, in_fire && in_cmd && status.pend_valid,
		state_q == ST_EMIT, "tick with pending pixel did not start search")
	`TLR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"pixel dropped before transfer")

endmodule

// ===== src/tlr_datapath.sv =====
// datapath: line walker, ring stepper and prefetched pixel
module tlr_datapath import tlr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input tlr_cmd_t cmd,
	output tlr_status_t status,
	input coord_t start_x,
	input coord_t start_y,
	input coord_t end_x,
	input coord_t end_y,
	input logic [5:0] radius,
	output pix_t pixel_x,
	output pix_t pixel_y,
	output logic last
);

	coord_t walk_x_q, walk_y_q, target_x_q, target_y_q, prev_x_q, prev_y_q;
	logic signed [ErrBits-1:0] err_q;
	logic signed [DblBits-1:0] ddx_q, ddy_q;
	oct_t oct_q;
	brush_mode_t mode_q;
	ring_t rad_q, stop_q, rx_q, ry_q, dec_q;
	logic [5:0] seg_rad_q;
	logic [3:0] pidx_q;
	logic busy_q, phase_q, pend_valid_q, last_q;
	pix_t pend_x_q, pend_y_q, pix_x_q, pix_y_q;

	// load decode
	logic signed [CoordBits:0] dx, dy;
	logic signed [CoordBits+1:0] ndx, ndy;
	oct_t oct_ld;
	always_comb begin
		dx = (CoordBits+1)'(end_x) - (CoordBits+1)'(start_x);
		dy = (CoordBits+1)'(end_y) - (CoordBits+1)'(start_y);
		ndx = -(CoordBits+2)'(dx);
		ndy = -(CoordBits+2)'(dy);
		oct_ld = OCT_NONE;
		if (dx > 0) begin
			if (dy >= 0) oct_ld = (dx >= dy) ? OCT_1 : OCT_2;
			else oct_ld = ((CoordBits+2)'(dx) >= ndy) ? OCT_8 : OCT_7;
		end else if (dx < 0) begin
			if (dy > 0) oct_ld = (ndx >= (CoordBits+2)'(dy)) ? OCT_4 : OCT_3;
			else if (dy < 0) oct_ld = (dx <= dy) ? OCT_5 : OCT_6;
			else oct_ld = OCT_4;
		end else begin
			if (dy > 0) oct_ld = OCT_2;
			else if (dy < 0) oct_ld = OCT_6;
		end
	end

	// centre start: neighbour test and direction
	logic signed [CoordBits:0] wx17, wy17, px17, py17;
	logic far;
	brush_mode_t dir;
	always_comb begin
		wx17 = (CoordBits+1)'(walk_x_q);
		wy17 = (CoordBits+1)'(walk_y_q);
		px17 = (CoordBits+1)'(prev_x_q);
		py17 = (CoordBits+1)'(prev_y_q);
		far = (prev_x_q == '1) || (px17 < wx17 - 1) || (px17 > wx17 + 1) ||
			(py17 < wy17 - 1) || (py17 > wy17 + 1);
		if (prev_y_q < walk_y_q)
			dir = (prev_x_q < walk_x_q) ? MODE_D1 : ((prev_x_q == walk_x_q) ? MODE_D2 : MODE_D3);
		else if (prev_y_q == walk_y_q)
			dir = (prev_x_q > walk_x_q) ? MODE_D4 : ((prev_x_q < walk_x_q) ? MODE_D8 : MODE_FULL);
		else
			dir = (prev_x_q > walk_x_q) ? MODE_D5 : ((prev_x_q == walk_x_q) ? MODE_D6 : MODE_D7);
	end

	// bresenham step
	coord_t nwx, nwy;
	logic signed [ErrBits-1:0] e1, e2, edx, edy;
	logic hit, take2;
	always_comb begin
		edx = ErrBits'(ddx_q);
		edy = ErrBits'(ddy_q);
		nwx = walk_x_q;
		nwy = walk_y_q;
		e1 = err_q;
		e2 = err_q;
		hit = 1'b0;
		take2 = 1'b0;
		case (oct_q)
			OCT_1: begin
				nwx = walk_x_q + 1'b1; hit = nwx == target_x_q;
				e1 = err_q - edy; take2 = e1 < 0; e2 = e1 + edx;
				if (take2) nwy = walk_y_q + 1'b1;
			end
			OCT_2: begin
				nwy = walk_y_q + 1'b1; hit = nwy == target_y_q;
				e1 = err_q - edx; take2 = e1 < 0; e2 = e1 + edy;
				if (take2) nwx = walk_x_q + 1'b1;
			end
			OCT_3: begin
				nwy = walk_y_q + 1'b1; hit = nwy == target_y_q;
				e1 = err_q + edx; take2 = e1 <= 0; e2 = e1 + edy;
				if (take2) nwx = walk_x_q - 1'b1;
			end
			OCT_4: begin
				nwx = walk_x_q - 1'b1; hit = nwx == target_x_q;
				e1 = err_q + edy; take2 = e1 >= 0; e2 = e1 + edx;
				if (take2) nwy = walk_y_q + 1'b1;
			end
			OCT_5: begin
				nwx = walk_x_q - 1'b1; hit = nwx == target_x_q;
				e1 = err_q - edy; take2 = e1 >= 0; e2 = e1 + edx;
				if (take2) nwy = walk_y_q - 1'b1;
			end
			OCT_6: begin
				nwy = walk_y_q - 1'b1; hit = nwy == target_y_q;
				e1 = err_q - edx; take2 = e1 >= 0; e2 = e1 + edy;
				if (take2) nwx = walk_x_q - 1'b1;
			end
			OCT_7: begin
				nwy = walk_y_q - 1'b1; hit = nwy == target_y_q;
				e1 = err_q + edx; take2 = e1 > 0; e2 = e1 + edy;
				if (take2) nwx = walk_x_q + 1'b1;
			end
			OCT_8: begin
				nwx = walk_x_q + 1'b1; hit = nwx == target_x_q;
				e1 = err_q + edy; take2 = e1 < 0; e2 = e1 + edx;
				if (take2) nwy = walk_y_q - 1'b1;
			end
			default: hit = 1'b1;
		endcase
	end

	// ring point and decision update
	logic [3:0] npts;
	pt_code_t code;
	ring_t ox, oy;
	logic signed [RingBits+1:0] x2, ryd, dec11, ndec;
	ring_t nrx, nry;
	always_comb begin
		npts = point_count(mode_q, rx_q, ry_q);
		code = point_code(mode_q, rx_q, ry_q, pidx_q[2:0]);
		case (code)
			PT_XY: begin ox = rx_q; oy = ry_q; end
			PT_YX: begin ox = ry_q; oy = rx_q; end
			PT_NXY: begin ox = -rx_q; oy = ry_q; end
			PT_NYX: begin ox = -ry_q; oy = rx_q; end
			PT_NYNX: begin ox = -ry_q; oy = -rx_q; end
			PT_NXNY: begin ox = -rx_q; oy = -ry_q; end
			PT_XNY: begin ox = rx_q; oy = -ry_q; end
			default: begin ox = ry_q; oy = -rx_q; end
		endcase
		x2 = (RingBits+2)'(rx_q) + (RingBits+2)'(rx_q);
		ryd = (RingBits+2)'(rad_q) - (RingBits+2)'(ry_q);
		dec11 = (RingBits+2)'(dec_q);
		nrx = rx_q;
		nry = ry_q;
		if (dec11 >= x2) begin
			ndec = dec11 - x2 - 2'sd1;
			nrx = rx_q + 1'b1;
		end else if (dec11 <= ryd + ryd) begin
			ndec = dec11 + (RingBits+2)'(ry_q) + (RingBits+2)'(ry_q) - 2'sd1;
			nry = ry_q - 1'b1;
		end else begin
			ndec = dec11 + (RingBits+2)'(ry_q) - (RingBits+2)'(rx_q)
				+ (RingBits+2)'(ry_q) - (RingBits+2)'(rx_q) - 3'sd2;
			nry = ry_q - 1'b1;
			nrx = rx_q + 1'b1;
		end
	end

	// one search step
	logic found;
	pix_t fx, fy;
	ring_t seg_rad9;
	always_comb begin
		seg_rad9 = RingBits'(seg_rad_q);
		found = 1'b0;
		fx = wx17;
		fy = wy17;
		if (busy_q) begin
			if (!phase_q) begin
				found = far;
			end else if (!(rad_q <= stop_q) && !(ry_q < rx_q) && (pidx_q < npts)) begin
				found = 1'b1;
				fx = wx17 + (CoordBits+1)'(ox);
				fy = wy17 + (CoordBits+1)'(oy);
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (cmd.load) begin
			busy_q <= oct_ld != OCT_NONE;
			phase_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (cmd.step) begin
			if (!busy_q) begin
				pend_valid_q <= 1'b0;
			end else if (!phase_q) begin
				phase_q <= 1'b1;
				if (far) pend_valid_q <= 1'b1;
			end else if (rad_q <= stop_q) begin
				phase_q <= 1'b0;
				if (hit) busy_q <= 1'b0;
			end else if (found) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	// walker, ring and pixel registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			walk_x_q <= start_x;
			walk_y_q <= start_y;
			target_x_q <= end_x;
			target_y_q <= end_y;
			oct_q <= oct_ld;
			err_q <= (oct_ld == OCT_1 || oct_ld == OCT_4 || oct_ld == OCT_5 || oct_ld == OCT_8)
				? ErrBits'(dx) : ErrBits'(dy);
			ddx_q <= DblBits'(dx) + DblBits'(dx);
			ddy_q <= DblBits'(dy) + DblBits'(dy);
			prev_x_q <= '1;
			prev_y_q <= '1;
			seg_rad_q <= radius;
		end
		if (cmd.take) begin
			pix_x_q <= pend_x_q;
			pix_y_q <= pend_y_q;
		end
		if (cmd.step) begin
			if (!busy_q) begin
				last_q <= 1'b1;
			end else if (!phase_q) begin
				mode_q <= far ? MODE_FULL : dir;
				rad_q <= seg_rad9;
				stop_q <= far ? '0 : ((dir == MODE_FULL) ? seg_rad9 : seg_rad9 - 3'sd2);
				rx_q <= '0;
				ry_q <= seg_rad9;
				dec_q <= seg_rad9 - 1'b1;
				pidx_q <= '0;
				prev_x_q <= walk_x_q;
				prev_y_q <= walk_y_q;
			end else if (rad_q <= stop_q) begin
				if (!hit) begin
					walk_x_q <= nwx;
					walk_y_q <= nwy;
					err_q <= take2 ? e2 : e1;
				end
			end else if (ry_q < rx_q) begin
				rad_q <= rad_q - 1'b1;
				rx_q <= '0;
				ry_q <= rad_q - 1'b1;
				dec_q <= rad_q - 3'sd2;
				pidx_q <= '0;
			end else if (pidx_q < npts) begin
				pidx_q <= pidx_q + 1'b1;
			end else begin
				rx_q <= nrx;
				ry_q <= nry;
				dec_q <= RingBits'(ndec);
				pidx_q <= '0;
			end
			if (found) begin
				pend_x_q <= fx;
				pend_y_q <= fy;
				last_q <= 1'b0;
			end
		end
	end

	assign status = '{pend_valid: pend_valid_q, busy: busy_q, found: found};
	assign pixel_x = pix_x_q;
	assign pixel_y = pix_y_q;
	assign last = last_q;

endmodule
